/* sv/lrbp_pkg.sv */
package lrbp_pkg;

    localparam int ID_BITS     = 3;
    localparam int WORD_BITS   = 32;
    localparam int VAR_ID_W    = 3;
    localparam int LEN_W       = 6;
    localparam int SCALE_W     = 8;
    localparam int FILL_W      = $clog2(WORD_BITS);
    localparam int CNT_W       = $clog2(ID_BITS + WORD_BITS + 1);
    localparam int ID_IDX_W    = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;
    localparam int DIV_CNT_W   = $clog2(WORD_BITS);
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W   = ((VAR_ID_W + WORD_BITS + 7) / 8) * 8;
    localparam int LEN_TABLE_W = 48;
    localparam int SCL_TABLE_W = 64;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;

    localparam logic [LEN_W-1:0]     MAX_LEN      = 6'd32;
    localparam logic [FILL_W-1:0]    STUFF_RUN    = 5'd30;
    localparam logic [FILL_W-1:0]    FILL_LAST    = FILL_W'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] SESSION_MARK = 32'hFFFF_FFFE;
    localparam logic [VAR_ID_W-1:0]  RESERVED_ID  = 3'd7;

    localparam logic [LEN_TABLE_W-1:0] LEN_RESET   = 48'd71485708370960;
    localparam logic [SCL_TABLE_W-1:0] SCALE_RESET = 64'h0101_0101_0101_0101;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_SESSION = 1'b1;

    // register select is address bit 3 (8-byte stride)
    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_SCALE  = 1'b1;

    typedef struct packed {
        logic                 session;
        logic [ID_BITS-1:0]   id;
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PUMP,
        B_FLUSH,
        B_SESSION
    } back_state_t;

endpackage

/* sv/lrbp_front.sv */
module lrbp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lrbp_pkg::IN_DATA_W-1:0]      s_tdata,   // var_id, raw_value
    input  logic [0:0]                          s_tuser,   // opcode
    input  logic [lrbp_pkg::LEN_TABLE_W-1:0]    length_table,
    input  logic [lrbp_pkg::SCL_TABLE_W-1:0]    scale_table,
    output lrbp_pkg::cmd_t                      push_cmd,
    output logic                                push_valid,
    input  logic                                q_full
);

    lrbp_pkg::front_state_t                 state_reg, state_next;
    logic                                   session_reg, session_next;
    logic [lrbp_pkg::ID_BITS-1:0]           id_reg, id_next;
    logic [lrbp_pkg::LEN_W-1:0]             len_reg, len_next;
    logic [lrbp_pkg::SCALE_W-1:0]           div_reg, div_next;
    logic [lrbp_pkg::WORD_BITS-1:0]         quo_reg, quo_next;
    logic [lrbp_pkg::SCALE_W-1:0]           rem_reg, rem_next;
    logic [lrbp_pkg::DIV_CNT_W-1:0]         cnt_reg, cnt_next;

    logic [lrbp_pkg::VAR_ID_W-1:0]          acc_id;
    logic [lrbp_pkg::WORD_BITS-1:0]         acc_raw;
    logic [lrbp_pkg::LEN_W-1:0]             len_sel;
    logic [lrbp_pkg::SCALE_W-1:0]           scale_sel;
    logic [lrbp_pkg::SCALE_W:0]             trial;
    logic [lrbp_pkg::SCALE_W:0]             diff;
    logic                                   ge;
    logic [lrbp_pkg::WORD_BITS-1:0]         top;
    logic [lrbp_pkg::WORD_BITS-1:0]         sat_val;

    assign acc_id    = s_tdata[lrbp_pkg::VAR_ID_W-1:0];
    assign acc_raw   = s_tdata[lrbp_pkg::VAR_ID_W +: lrbp_pkg::WORD_BITS];
    assign len_sel   = length_table[lrbp_pkg::LEN_W*acc_id +: lrbp_pkg::LEN_W];
    assign scale_sel = scale_table[lrbp_pkg::SCALE_W*acc_id +: lrbp_pkg::SCALE_W];

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[lrbp_pkg::WORD_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    assign top = lrbp_pkg::WORD_BITS'(({1'b0, {lrbp_pkg::WORD_BITS{1'b0}}} | 33'd1) << len_reg)
                 - lrbp_pkg::WORD_BITS'(1);

    always_comb begin
        if (len_reg < lrbp_pkg::MAX_LEN && quo_reg > top) begin
            sat_val = top;
        end else begin
            sat_val = quo_reg;
        end
    end

    assign s_tready   = (state_reg == lrbp_pkg::F_IDLE);
    assign push_valid = (state_reg == lrbp_pkg::F_PUSH);

    always_comb begin
        push_cmd.session = session_reg;
        push_cmd.id      = id_reg;
        push_cmd.len     = len_reg;
        push_cmd.value   = sat_val;
    end

    always_comb begin
        state_next   = state_reg;
        session_next = session_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            lrbp_pkg::F_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == lrbp_pkg::OP_SESSION) begin
                        session_next = 1'b1;
                        state_next   = lrbp_pkg::F_PUSH;
                    end else if (acc_id != lrbp_pkg::RESERVED_ID) begin
                        session_next = 1'b0;
                        id_next      = lrbp_pkg::ID_BITS'(acc_id);
                        len_next     = (len_sel > lrbp_pkg::MAX_LEN) ? lrbp_pkg::MAX_LEN
                                                                     : len_sel;
                        div_next     = (scale_sel == '0) ? lrbp_pkg::SCALE_W'(1) : scale_sel;
                        quo_next     = acc_raw;
                        rem_next     = '0;
                        cnt_next     = '0;
                        state_next   = lrbp_pkg::F_DIV;
                    end
                end
            end
            lrbp_pkg::F_DIV: begin
                quo_next = {quo_reg[lrbp_pkg::WORD_BITS-2:0], ge};
                rem_next = ge ? diff[lrbp_pkg::SCALE_W-1:0] : trial[lrbp_pkg::SCALE_W-1:0];
                cnt_next = cnt_reg + lrbp_pkg::DIV_CNT_W'(1);
                if (cnt_reg == {lrbp_pkg::DIV_CNT_W{1'b1}}) begin
                    state_next = lrbp_pkg::F_PUSH;
                end
            end
            lrbp_pkg::F_PUSH: begin
                if (!q_full) begin
                    state_next = lrbp_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = lrbp_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrbp_pkg::F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        session_reg <= session_next;
        id_reg      <= id_next;
        len_reg     <= len_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
    end

endmodule

/* sv/lrbp_fifo.sv */
module lrbp_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lrbp_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output lrbp_pkg::cmd_t  pop_cmd,
    output logic            empty
);

    localparam int PTR_W = (lrbp_pkg::QUEUE_DEPTH > 1) ? $clog2(lrbp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lrbp_pkg::QUEUE_DEPTH + 1);

    lrbp_pkg::cmd_t     entry_reg [lrbp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(lrbp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lrbp_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lrbp_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/lrbp_back.sv */
module lrbp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lrbp_pkg::cmd_t                  pop_cmd,
    input  logic                            q_empty,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lrbp_pkg::WORD_BITS-1:0]  m_tdata,   // store_word
    output logic                            m_tlast    // last_word
);

    lrbp_pkg::back_state_t              state_reg, state_next;
    logic [lrbp_pkg::ID_BITS-1:0]       id_reg, id_next;
    logic [lrbp_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [lrbp_pkg::WORD_BITS-1:0]     val_reg, val_next;
    logic [lrbp_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [lrbp_pkg::WORD_BITS-1:0]     word_reg, word_next;
    logic [lrbp_pkg::FILL_W-1:0]        fill_reg, fill_next;
    logic [lrbp_pkg::FILL_W-1:0]        ones_reg, ones_next;
    logic                               stuff_reg, stuff_next;
    logic [lrbp_pkg::WORD_BITS-1:0]     pend_reg, pend_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [lrbp_pkg::WORD_BITS-1:0]     out_data_reg, out_data_next;
    logic                               out_last_reg, out_last_next;
    logic                               out_valid_reg, out_valid_next;

    logic [lrbp_pkg::CNT_W-1:0]         pos;
    logic [lrbp_pkg::ID_IDX_W-1:0]      id_idx;
    logic                               src_bit;
    logic                               in_bit;
    logic                               adv;
    logic                               insert;
    logic                               done;
    logic                               stall;
    logic                               out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    // id bits first, then value bits, each MSB first
    assign pos    = rem_reg - lrbp_pkg::CNT_W'(1);
    assign id_idx = lrbp_pkg::ID_IDX_W'(pos - lrbp_pkg::CNT_W'(len_reg));

    always_comb begin
        if (pos < lrbp_pkg::CNT_W'(len_reg)) begin
            src_bit = val_reg[pos[lrbp_pkg::FILL_W-1:0]];
        end else begin
            src_bit = id_reg[id_idx];
        end
    end

    assign insert = !stuff_reg && src_bit && (ones_reg >= lrbp_pkg::STUFF_RUN);
    assign in_bit = stuff_reg ? 1'b1 : (insert ? 1'b0 : src_bit);
    assign adv    = !insert;
    assign done   = (fill_reg == lrbp_pkg::FILL_LAST);
    assign stall  = done && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        rem_next        = rem_reg;
        word_next       = word_reg;
        fill_next       = fill_reg;
        ones_next       = ones_reg;
        stuff_next      = stuff_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        pop             = 1'b0;
        case (state_reg)
            lrbp_pkg::B_IDLE: begin
                if (!q_empty) begin
                    pop = 1'b1;
                    if (pop_cmd.session) begin
                        state_next = lrbp_pkg::B_SESSION;
                    end else begin
                        id_next    = pop_cmd.id;
                        len_next   = pop_cmd.len;
                        val_next   = pop_cmd.value;
                        rem_next   = lrbp_pkg::CNT_W'(lrbp_pkg::ID_BITS)
                                     + lrbp_pkg::CNT_W'(pop_cmd.len);
                        stuff_next = 1'b0;
                        state_next = lrbp_pkg::B_PUMP;
                    end
                end
            end
            lrbp_pkg::B_PUMP: begin
                if (!stall) begin
                    word_next = {in_bit, word_reg[lrbp_pkg::WORD_BITS-1:1]};
                    fill_next = fill_reg + lrbp_pkg::FILL_W'(1);
                    if (stuff_reg) begin
                        stuff_next = 1'b0;
                    end else if (insert) begin
                        ones_next  = lrbp_pkg::FILL_W'(1);
                        stuff_next = 1'b1;
                    end else if (src_bit) begin
                        ones_next = ones_reg + lrbp_pkg::FILL_W'(1);
                    end else begin
                        ones_next = '0;
                    end
                    if (done) begin
                        if (pend_valid_reg) begin
                            out_data_next  = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = word_next;
                        pend_valid_next = 1'b1;
                    end
                    if (adv) begin
                        rem_next = rem_reg - lrbp_pkg::CNT_W'(1);
                        if (rem_reg == lrbp_pkg::CNT_W'(1)) begin
                            state_next = lrbp_pkg::B_FLUSH;
                        end
                    end
                end
            end
            lrbp_pkg::B_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = lrbp_pkg::B_IDLE;
                end else if (out_free) begin
                    out_data_next   = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = lrbp_pkg::B_IDLE;
                end
            end
            lrbp_pkg::B_SESSION: begin
                if (out_free) begin
                    out_data_next  = lrbp_pkg::SESSION_MARK;
                    out_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    word_next      = '0;
                    fill_next      = '0;
                    ones_next      = '0;
                    state_next     = lrbp_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = lrbp_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lrbp_pkg::B_IDLE;
            rem_reg        <= '0;
            word_reg       <= '0;
            fill_reg       <= '0;
            ones_reg       <= '0;
            stuff_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rem_reg        <= rem_next;
            word_reg       <= word_next;
            fill_reg       <= fill_next;
            ones_reg       <= ones_next;
            stuff_reg      <= stuff_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        len_reg      <= len_next;
        val_reg      <= val_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lrbp_pkg::B_IDLE |-> !pend_valid_reg)
        else $error("pending word left at item end");

    a_stuff_run: assert property (@(posedge aclk) disable iff (!aresetn)
        stuff_reg |-> (ones_reg == lrbp_pkg::FILL_W'(1)) && state_reg == lrbp_pkg::B_PUMP)
        else $error("stuffed zero with wrong run count");

    a_session_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lrbp_pkg::B_SESSION && out_free |=>
            out_valid_reg && out_last_reg && out_data_reg == lrbp_pkg::SESSION_MARK
            && fill_reg == '0 && ones_reg == '0)
        else $error("session marker not issued");
`endif

endmodule

/* sv/log_record_bit_packer_unit.sv */
// Write record: accept, bit-serial divide, enqueue and dequeue, then one cycle per emitted
// bit unless the output stalls (3 id bits, up to 32 value bits, stuffed zeros), plus a flush.
// Divider and bit pump overlap through a 2-entry queue, so the front can divide a new record
// while the pump still emits the last one. Session command: emits the session marker word.
// Reset (aresetn low, synchronous) empties the queue, clears the partial word and counters,
// and loads the length and scale tables with their defaults.
module log_record_bit_packer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lrbp_pkg::IN_DATA_W-1:0]      s_tdata,   // [2:0] var_id, [34:3] raw_value
    input  logic [0:0]                          s_tuser,   // [0] opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lrbp_pkg::WORD_BITS-1:0]      m_tdata,   // [31:0] store_word
    output logic                                m_tlast,   // last_word
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrbp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lrbp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lrbp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [lrbp_pkg::LEN_TABLE_W-1:0]   length_reg;
    logic [lrbp_pkg::SCL_TABLE_W-1:0]   scale_reg;
    logic                               cfg_wr;

    lrbp_pkg::cmd_t                     push_cmd;
    lrbp_pkg::cmd_t                     pop_cmd;
    logic                               push_valid;
    logic                               q_full;
    logic                               q_empty;
    logic                               pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= lrbp_pkg::LEN_RESET;
            scale_reg  <= lrbp_pkg::SCALE_RESET;
        end else if (cfg_wr) begin
            if (paddr[3] == lrbp_pkg::REG_LENGTH) begin
                length_reg <= pwdata[lrbp_pkg::LEN_TABLE_W-1:0];
            end else begin
                scale_reg <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[3] == lrbp_pkg::REG_SCALE) begin
            prdata = scale_reg;
        end else begin
            prdata = lrbp_pkg::APB_DATA_W'(length_reg);
        end
    end

    lrbp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .length_table (length_reg),
        .scale_table  (scale_reg),
        .push_cmd     (push_cmd),
        .push_valid   (push_valid),
        .q_full       (q_full)
    );

    lrbp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    lrbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_cmd  (pop_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
